@@ rtl/core/dependency_transition_engine_top_macros.svh @@
// assertion macros for the dependency transition engine checker
// no dependencies; expects i_clk and i_rst_n in the using scope
`ifndef DEPENDENCY_TRANSITION_ENGINE_TOP_MACROS_SVH
`define DEPENDENCY_TRANSITION_ENGINE_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define DTE_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dte port check failed");

// next-cycle implication, off during reset
`define DTE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dte port check failed");

`endif

@@ rtl/core/dte_pkg.sv @@
// shared types and constants of the dependency transition engine
// no dependencies
package dte_pkg;

    localparam int C_MAX_WORDS   = 255;
    localparam int C_LABEL_BITS  = 8;
    localparam int C_STACK_DEPTH = C_MAX_WORDS + 1;
    localparam int C_BUFFER_CAP  = C_MAX_WORDS;
    localparam int C_ADDR_W      = $clog2(C_STACK_DEPTH);
    localparam int C_WORD_W      = 8;
    localparam int C_COUNT_W     = 9;

    typedef enum logic [2:0] {
        CMD_LEFT_ARC   = 3'd0,
        CMD_RIGHT_ARC  = 3'd1,
        CMD_SHIFT      = 3'd2,
        CMD_SWAP       = 3'd3,
        CMD_LEFT_ARC2  = 3'd4,
        CMD_RIGHT_ARC2 = 3'd5,
        CMD_START      = 3'd6
    } t_cmd;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd2;
        logic exec;
        logic wr2;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_wr2;
    } t_dp_stat;

endpackage

@@ rtl/core/dependency_transition_engine_top.sv @@
// a command taken while idle gives its result word with o_done high after the
// stack reads and the execute step; no new command is taken while busy, which
// lasts longer for an applicable left arc 2, set by the two-port stack memory
// reads and its single write port; the receiver cannot stall, o_done lasts one cycle
// reset (synchronous, active low) empties stack and buffer and clears the mode
module dependency_transition_engine_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   i_cmd,
    input  logic [dte_pkg::C_LABEL_BITS-1:0] i_arc_label,
    input  logic                         i_label_marks_root,
    input  logic [dte_pkg::C_WORD_W-1:0] i_word_count,
    // configuration channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_single_root_mode,
    // result channel
    output logic                         o_done,
    output logic                         o_accepted,
    output logic                         o_arc_made,
    output logic [dte_pkg::C_WORD_W-1:0] o_child_word,
    output logic [dte_pkg::C_WORD_W-1:0] o_parent_word,
    output logic [dte_pkg::C_LABEL_BITS-1:0] o_made_label,
    output logic [dte_pkg::C_COUNT_W-1:0] o_stack_depth,
    output logic [dte_pkg::C_WORD_W-1:0] o_buffer_depth
);
    import dte_pkg::*;

    // command and status between controller and datapath
    t_dp_cmd  w_dp_cmd;
    t_dp_stat w_dp_stat;

    // mode register takes a word at any time; user writes only while idle, not enforced
    assign o_cfg_ready = 1'b1;

    // sequencer: read top two, read third, execute, optional second write
    dte_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .o_done    (o_done),
        .o_dp_cmd  (w_dp_cmd),
        .i_dp_stat (w_dp_stat)
    );

    // stack and buffer memories, counts, rule checks, result registers
    dte_dpath u_dpath (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_dp_cmd               (w_dp_cmd),
        .o_dp_stat              (w_dp_stat),
        .i_cfg_valid            (i_cfg_valid),
        .i_cfg_single_root_mode (i_cfg_single_root_mode),
        .i_cmd                  (i_cmd),
        .i_arc_label            (i_arc_label),
        .i_label_marks_root     (i_label_marks_root),
        .i_word_count           (i_word_count),
        .o_accepted             (o_accepted),
        .o_arc_made             (o_arc_made),
        .o_child_word           (o_child_word),
        .o_parent_word          (o_parent_word),
        .o_made_label           (o_made_label),
        .o_stack_depth          (o_stack_depth),
        .o_buffer_depth         (o_buffer_depth)
    );

endmodule

@@ rtl/core/dte_ctrl.sv @@
// controller state machine of the dependency transition engine
// depends on dte_pkg
module dte_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_done,
    output dte_pkg::t_dp_cmd o_dp_cmd,
    input  dte_pkg::t_dp_stat i_dp_stat
);
    import dte_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ1,
        ST_READ2,
        ST_EXEC,
        ST_WR2
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_state <= ST_READ1;
                        r_busy  <= 1'b1;
                    end
                end
                ST_READ1: r_state <= ST_READ2;
                ST_READ2: r_state <= ST_EXEC;
                ST_EXEC: begin
                    r_done <= 1'b1;
                    if (i_dp_stat.need_wr2) begin
                        r_state <= ST_WR2;
                    end else begin
                        r_state <= ST_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                ST_WR2: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= ST_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_dp_cmd      = '0;
        o_dp_cmd.load = start && !r_busy;
        o_dp_cmd.rd2  = (r_state == ST_READ2);
        o_dp_cmd.exec = (r_state == ST_EXEC);
        o_dp_cmd.wr2  = (r_state == ST_WR2);
    end

    assign busy   = r_busy;
    assign o_done = r_done;

endmodule

@@ rtl/core/dte_dpath.sv @@
// datapath of the dependency transition engine: stack and buffer memories,
// counts, applicability checks and result registers; depends on dte_pkg
module dte_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dte_pkg::t_dp_cmd             i_dp_cmd,
    output dte_pkg::t_dp_stat            o_dp_stat,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_single_root_mode,
    input  logic [2:0]                   i_cmd,
    input  logic [dte_pkg::C_LABEL_BITS-1:0] i_arc_label,
    input  logic                         i_label_marks_root,
    input  logic [dte_pkg::C_WORD_W-1:0] i_word_count,
    output logic                         o_accepted,
    output logic                         o_arc_made,
    output logic [dte_pkg::C_WORD_W-1:0] o_child_word,
    output logic [dte_pkg::C_WORD_W-1:0] o_parent_word,
    output logic [dte_pkg::C_LABEL_BITS-1:0] o_made_label,
    output logic [dte_pkg::C_COUNT_W-1:0] o_stack_depth,
    output logic [dte_pkg::C_WORD_W-1:0] o_buffer_depth
);
    import dte_pkg::*;

    logic [C_WORD_W-1:0]     r_stack  [C_STACK_DEPTH];
    logic [C_WORD_W-1:0]     r_buffer [C_STACK_DEPTH];

    logic                    r_sr;
    logic [C_COUNT_W-1:0]    r_s;
    logic [C_COUNT_W-1:0]    r_bc;
    logic [C_COUNT_W-1:0]    r_mark;
    logic [C_WORD_W-1:0]     r_n;

    logic [2:0]              r_cmd;
    logic [C_LABEL_BITS-1:0] r_label;
    logic                    r_rootlab;
    logic [C_WORD_W-1:0]     r_wcnt;

    logic [C_WORD_W-1:0]     r_rd_a;
    logic [C_WORD_W-1:0]     r_rd_b;
    logic [C_WORD_W-1:0]     r_rd_buf;
    logic [C_WORD_W-1:0]     r_top;
    logic [C_ADDR_W-1:0]     r_wr2_addr;
    logic [C_WORD_W-1:0]     r_wr2_data;

    logic                    r_accepted;
    logic                    r_arc_made;
    logic [C_WORD_W-1:0]     r_child;
    logic [C_WORD_W-1:0]     r_parent;
    logic [C_LABEL_BITS-1:0] r_made_label;

    logic [C_ADDR_W-1:0]     w_addr_a;
    logic [C_ADDR_W-1:0]     w_addr_b;
    logic [C_ADDR_W-1:0]     w_addr_buf;
    logic [C_WORD_W-1:0]     w_front;
    logic [C_WORD_W-1:0]     w_n_sat;
    logic                    w_sr_root;
    logic                    w_ok;
    logic                    w_arc;
    logic                    w_la2;
    logic [C_WORD_W-1:0]     w_child;
    logic [C_WORD_W-1:0]     w_parent;
    logic [C_COUNT_W-1:0]    n_s;
    logic [C_COUNT_W-1:0]    n_bc;
    logic [C_COUNT_W-1:0]    n_mark;
    logic                    w_stk_we;
    logic [C_ADDR_W-1:0]     w_stk_addr;
    logic [C_WORD_W-1:0]     w_stk_wdata;
    logic                    w_buf_we;
    logic [C_WORD_W-1:0]     w_buf_wdata;

    // read addresses follow the counts
    assign w_addr_a   = i_dp_cmd.rd2 ? C_ADDR_W'(r_s - 9'd3) : C_ADDR_W'(r_s - 9'd1);
    assign w_addr_b   = C_ADDR_W'(r_s - 9'd2);
    assign w_addr_buf = C_ADDR_W'(r_bc - 9'd1);

    // entries below the mark still hold the start pattern n - i
    assign w_front = ({1'b0, w_addr_buf} < r_mark) ? (r_n - w_addr_buf) : r_rd_buf;

    assign w_n_sat = ({1'b0, r_wcnt} > C_COUNT_W'(C_MAX_WORDS)) ?
                     C_WORD_W'(C_MAX_WORDS) : r_wcnt;

    assign w_sr_root = r_sr && r_rootlab;

    always_comb begin
        w_ok        = 1'b0;
        w_arc       = 1'b0;
        w_la2       = 1'b0;
        w_child     = '0;
        w_parent    = '0;
        n_s         = r_s;
        n_bc        = r_bc;
        n_mark      = r_mark;
        w_stk_we    = 1'b0;
        w_stk_addr  = C_ADDR_W'(r_s - 9'd2);
        w_stk_wdata = r_top;
        w_buf_we    = 1'b0;
        w_buf_wdata = r_rd_b;
        case (r_cmd)
            CMD_LEFT_ARC: begin
                if (!w_sr_root && r_s >= 9'd2 && r_rd_b != '0) begin
                    w_ok     = 1'b1;
                    w_arc    = 1'b1;
                    w_parent = r_top;
                    w_child  = r_rd_b;
                    w_stk_we = 1'b1;
                    n_s      = r_s - 9'd1;
                end
            end
            CMD_RIGHT_ARC: begin
                if (w_sr_root) begin
                    w_ok = (r_s == 9'd2) && (r_bc == '0);
                end else if (r_sr) begin
                    w_ok = (r_s > 9'd2);
                end else begin
                    w_ok = (r_s >= 9'd2);
                end
                if (w_ok) begin
                    w_arc    = 1'b1;
                    w_child  = r_top;
                    w_parent = r_rd_b;
                    n_s      = r_s - 9'd1;
                end
            end
            CMD_SHIFT: begin
                if (r_bc != '0 && r_s < C_COUNT_W'(C_STACK_DEPTH)) begin
                    w_ok        = 1'b1;
                    w_stk_we    = 1'b1;
                    w_stk_addr  = C_ADDR_W'(r_s);
                    w_stk_wdata = w_front;
                    n_s         = r_s + 9'd1;
                    n_bc        = r_bc - 9'd1;
                end
            end
            CMD_SWAP: begin
                if (r_s >= 9'd2 && r_rd_b != '0 && r_rd_b < r_top &&
                    r_bc < C_COUNT_W'(C_BUFFER_CAP)) begin
                    w_ok     = 1'b1;
                    w_stk_we = 1'b1;
                    w_buf_we = 1'b1;
                    n_s      = r_s - 9'd1;
                    n_bc     = r_bc + 9'd1;
                    if (r_bc < r_mark) begin
                        n_mark = r_bc;
                    end
                end
            end
            CMD_LEFT_ARC2: begin
                if (!w_sr_root && r_s >= 9'd3 && r_rd_a != '0) begin
                    w_ok     = 1'b1;
                    w_arc    = 1'b1;
                    w_la2    = 1'b1;
                    w_child  = r_rd_a;
                    w_parent = r_top;
                    w_stk_we = 1'b1;
                    n_s      = r_s - 9'd1;
                end
            end
            CMD_RIGHT_ARC2: begin
                if (!w_sr_root && r_s >= (r_sr ? 9'd4 : 9'd3) &&
                    r_bc < C_COUNT_W'(C_BUFFER_CAP)) begin
                    w_ok     = 1'b1;
                    w_arc    = 1'b1;
                    w_child  = r_top;
                    w_parent = r_rd_a;
                    w_buf_we = 1'b1;
                    n_s      = r_s - 9'd2;
                    n_bc     = r_bc + 9'd1;
                    if (r_bc < r_mark) begin
                        n_mark = r_bc;
                    end
                end
            end
            CMD_START: begin
                w_ok        = 1'b1;
                w_stk_we    = 1'b1;
                w_stk_addr  = '0;
                w_stk_wdata = '0;
                n_s         = 9'd1;
                n_bc        = {1'b0, w_n_sat};
                n_mark      = {1'b0, w_n_sat};
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase
    end

    assign o_dp_stat.need_wr2 = w_la2;

    // memories: one write, registered reads
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.wr2) begin
            r_stack[r_wr2_addr] <= r_wr2_data;
        end else if (i_dp_cmd.exec && w_stk_we) begin
            r_stack[w_stk_addr] <= w_stk_wdata;
        end
        r_rd_a <= r_stack[w_addr_a];
        r_rd_b <= r_stack[w_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.exec && w_buf_we) begin
            r_buffer[C_ADDR_W'(r_bc)] <= w_buf_wdata;
        end
        r_rd_buf <= r_buffer[w_addr_buf];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr   <= 1'b0;
            r_s    <= '0;
            r_bc   <= '0;
            r_mark <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_sr <= i_cfg_single_root_mode;
            end
            if (i_dp_cmd.exec) begin
                r_s    <= n_s;
                r_bc   <= n_bc;
                r_mark <= n_mark;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_cmd     <= i_cmd;
            r_label   <= i_arc_label;
            r_rootlab <= i_label_marks_root;
            r_wcnt    <= i_word_count;
        end
        if (i_dp_cmd.rd2) begin
            r_top <= r_rd_a;
        end
        if (i_dp_cmd.exec) begin
            r_wr2_addr   <= C_ADDR_W'(r_s - 9'd3);
            r_wr2_data   <= r_rd_b;
            r_accepted   <= w_ok;
            r_arc_made   <= w_arc;
            r_child      <= w_arc ? w_child : '0;
            r_parent     <= w_arc ? w_parent : '0;
            r_made_label <= w_arc ? r_label : '0;
            if (r_cmd == CMD_START) begin
                r_n <= w_n_sat;
            end
        end
    end

    assign o_accepted     = r_accepted;
    assign o_arc_made     = r_arc_made;
    assign o_child_word   = r_child;
    assign o_parent_word  = r_parent;
    assign o_made_label   = r_made_label;
    assign o_stack_depth  = r_s;
    assign o_buffer_depth = C_WORD_W'(r_bc);

endmodule

@@ rtl/core/dte_checker.sv @@
// port-level checks of the dependency transition engine and their bind
// depends on dte_pkg and dependency_transition_engine_top_macros.svh
`include "dependency_transition_engine_top_macros.svh"

module dte_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_done,
    input logic                         o_accepted,
    input logic                         o_arc_made,
    input logic [dte_pkg::C_WORD_W-1:0] o_child_word,
    input logic [dte_pkg::C_WORD_W-1:0] o_parent_word,
    input logic [dte_pkg::C_LABEL_BITS-1:0] o_made_label
);
    import dte_pkg::*;

    logic w_arc_fields_zero;

    assign w_arc_fields_zero = (o_child_word == '0) && (o_parent_word == '0) && (o_made_label == '0);

    // a taken command holds the engine busy
    `DTE_ASSERT_NEXT(a_take_busy, start && !busy, busy)
    // every taken command yields one result word, marked by o_done
    `DTE_ASSERT_IMPL(a_take_done, start && !busy, ##4 o_done)
    // result strobe lasts one cycle
    `DTE_ASSERT_NEXT(a_done_pulse, o_done, !o_done)
    // an arc only comes from a performed command
    `DTE_ASSERT_IMPL(a_arc_acc, o_done && o_arc_made, o_accepted)
    // no arc means zero arc fields
    `DTE_ASSERT_IMPL(a_no_arc_zero, o_done && !o_arc_made, w_arc_fields_zero)

endmodule

bind dependency_transition_engine_top dte_checker u_dte_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_accepted    (o_accepted),
    .o_arc_made    (o_arc_made),
    .o_child_word  (o_child_word),
    .o_parent_word (o_parent_word),
    .o_made_label  (o_made_label)
);
